// ===== sv/hamming_sec_encode_syndrome_core_macros.svh =====
// Assertion macros shared by the Hamming encoder and syndrome core.
`ifndef HAMMING_SEC_ENCODE_SYNDROME_CORE_MACROS_SVH
`define HAMMING_SEC_ENCODE_SYNDROME_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define HSEC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsec assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define HSEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsec assertion failed");
`else
`define HSEC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HSEC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/hsec_pkg.sv =====
// Types and constants of the Hamming encoder and syndrome core.
`timescale 1ns / 1ps
package hsec_pkg;

   localparam int DATA_BITS = 57;
   localparam int CODE_BITS = 63;
   localparam int SYN_BITS  = 6;

   // Item kinds.
   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // Data length after reset.
   localparam logic [SYN_BITS-1:0] DATA_LEN_RESET = 6'd4;

   typedef struct packed {
      logic                 kind;
      logic [DATA_BITS-1:0] data_word;
      logic [CODE_BITS-1:0] received_word;
   } req_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] codeword;
      logic [SYN_BITS-1:0]  error_position;
      logic                 error_found;
   } rsp_type;

endpackage

// ===== sv/hamming_sec_encode_syndrome_core.sv =====
// Hamming single-error code core: encodes data words and computes syndromes.
`timescale 1ns / 1ps
// The core takes one word per cycle while req_stall is low and returns one result
// word for each, held first in the input register and then in the result register.
// An encode word spreads the first data_len data bits over the
// non-power-of-two positions and sets the parity positions 1, 2, 4, ... to even
// parity; a decode word returns the XOR of the positions of its set bits within
// the code length, which is the position of a single flipped bit, or zero.
// data_len is clamped to 1..MAX_DATA_BITS and must only be written while no
// word is in flight. req_stall follows rsp_stall in the same cycle when both
// register stages are full.
`include "hamming_sec_encode_syndrome_core_macros.svh"

module hamming_sec_encode_syndrome_core
   import hsec_pkg::*;
#(
   parameter int MAX_DATA_BITS = 57
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [SYN_BITS-1:0] csr_wr_data
);

   // Bit index of the j-th data bit: the j-th position that is not a power of two.
   function automatic logic [SYN_BITS-1:0] data_bit_pos(input int j);
      int cnt;
      logic [SYN_BITS-1:0] pos;
      cnt = 0;
      pos = '0;
      for (int p = 1; p <= CODE_BITS; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (cnt == j) begin
               pos = SYN_BITS'(p - 1);
            end
            cnt++;
         end
      end
      return pos;
   endfunction

   // XOR of the one-based positions of all set bits.
   function automatic logic [SYN_BITS-1:0] syndrome_of(input logic [CODE_BITS-1:0] w);
      logic [SYN_BITS-1:0] s;
      s = '0;
      for (int b = 0; b < CODE_BITS; b++) begin
         if (w[b]) begin
            s ^= SYN_BITS'(b + 1);
         end
      end
      return s;
   endfunction

   // Least r with 2^r >= k + r + 1, from the thresholds of k.
   function automatic logic [2:0] parity_count(input logic [SYN_BITS-1:0] k);
      logic [2:0] r;
      if (k <= 6'd1) begin
         r = 3'd2;
      end else if (k <= 6'd4) begin
         r = 3'd3;
      end else if (k <= 6'd11) begin
         r = 3'd4;
      end else if (k <= 6'd26) begin
         r = 3'd5;
      end else begin
         r = 3'd6;
      end
      return r;
   endfunction

   logic [SYN_BITS-1:0] data_len_reg_ff;
   logic                s1_valid_ff;
   req_type             s1_word_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_word_ff;
   rsp_type             rsp_word_in;
   logic                out_ready;
   logic [SYN_BITS-1:0] eff_k;
   logic [SYN_BITS-1:0] code_len;
   logic [DATA_BITS-1:0] data_m;
   logic [CODE_BITS-1:0] rx_m;
   logic [CODE_BITS-1:0] cw_data;
   logic [CODE_BITS-1:0] cw_full;
   logic [SYN_BITS-1:0]  enc_syn;
   logic [SYN_BITS-1:0]  dec_syn;

   // The result register can take a word when empty or when its word leaves.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_len_reg_ff <= DATA_LEN_RESET;
      end else begin
         if (csr_wr_en) begin
            data_len_reg_ff <= csr_wr_data;
         end
      end
   end

   // Effective data length and code length.
   always_comb begin
      if (data_len_reg_ff == '0) begin
         eff_k = 6'd1;
      end else if (data_len_reg_ff > SYN_BITS'(MAX_DATA_BITS)) begin
         eff_k = SYN_BITS'(MAX_DATA_BITS);
      end else begin
         eff_k = data_len_reg_ff;
      end
      code_len = eff_k + SYN_BITS'(parity_count(eff_k));
   end

   // Encode: place the used data bits, then set parity from their syndrome.
   always_comb begin
      for (int j = 0; j < DATA_BITS; j++) begin
         data_m[j] = s1_word_ff.data_word[j] && (SYN_BITS'(j) < eff_k);
      end
      cw_data = '0;
      for (int j = 0; j < DATA_BITS; j++) begin
         cw_data[data_bit_pos(j)] = data_m[j];
      end
      enc_syn = syndrome_of(cw_data);
      cw_full = cw_data;
      for (int i = 0; i < SYN_BITS; i++) begin
         cw_full[(1 << i) - 1] = enc_syn[i];
      end
   end

   // Decode: syndrome over the positions within the code length.
   always_comb begin
      for (int b = 0; b < CODE_BITS; b++) begin
         rx_m[b] = s1_word_ff.received_word[b] && (SYN_BITS'(b) < code_len);
      end
      dec_syn = syndrome_of(rx_m);
   end

   // Result word by kind.
   always_comb begin
      rsp_word_in = '0;
      if (s1_word_ff.kind == KIND_ENCODE) begin
         rsp_word_in.codeword = cw_full;
      end else begin
         rsp_word_in.error_position = dec_syn;
         rsp_word_in.error_found    = (dec_syn != '0);
      end
   end

   // Input and result register stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_word_ff <= req_data;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // An accepted word always reaches the input register.
   `HSEC_ASSERT_NEXT(a_accept_loads, clock, reset, req_valid && !req_stall, s1_valid_ff)
   // A word moves on to the result register whenever that register is free.
   `HSEC_ASSERT_NEXT(a_stage_moves, clock, reset, s1_valid_ff && out_ready, rsp_valid)
   // The input side stalls only when both stages are full.
   `HSEC_ASSERT_NOW(a_stall_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff)
   // Encode results carry no error report.
   `HSEC_ASSERT_NEXT(a_encode_clean, clock, reset,
      s1_valid_ff && out_ready && s1_word_ff.kind == KIND_ENCODE,
      !rsp_data.error_found && rsp_data.error_position == '0)

endmodule
